// File: sv/fdq_pkg.sv
`default_nettype none

package fdq_pkg;

  // Width of a timestamp in milliseconds.
  localparam int TimeBits = 40;

  localparam int MaxCs      = 65535;
  localparam int BaseUnits  = 1000;
  localparam int CsPerMsDiv = 10;
  localparam int MaxRate    = 240;
  localparam int ResetRate  = 30;

  // A multiplied interval never exceeds MaxCs * CsPerMsDiv ms, which fits in DurBits.
  localparam int DurBits  = 20;
  localparam int RateBits = 8;
  localparam int ProdBits = DurBits + RateBits;
  // The divisor is rate * 10 (at most 2400), the remainder stays below it.
  localparam int RemBits  = 12;
  // The quotient never exceeds MaxCs + 239, which fits in QuoBits.
  localparam int QuoBits  = 17;
  localparam int CsBits   = 16;

  localparam int InDataBits = ((TimeBits + 1 + 7) / 8) * 8;
  localparam int FuncBits   = 2;

  localparam logic [TimeBits-1:0] MaxDurTs  = TimeBits'(MaxCs * CsPerMsDiv);
  localparam logic [RateBits-1:0] MaxRateV  = RateBits'(MaxRate);
  localparam logic [RateBits-1:0] ResetRateV = RateBits'(ResetRate);
  localparam logic [CsBits-1:0]   MaxCsV    = CsBits'(MaxCs);

  typedef enum logic [FuncBits-1:0] {
    FUNC_FRAME  = 2'd0,
    FUNC_FINISH = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  typedef struct packed {
    logic                start;
    logic [DurBits-1:0]  mcand;
    logic [RateBits-1:0] mplier;
    logic [RemBits-1:0]  addend;
  } mul_req_t;

  typedef struct packed {
    logic                done;
    logic [ProdBits-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic                start;
    logic [ProdBits-1:0] dividend;
    logic [RemBits-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [QuoBits-1:0] quo;
    logic [RemBits-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: sv/fdq_mul.sv
`default_nettype none

// Shift-and-add multiplier: one bit of the multiplier per cycle.
// The product starts from the addend, so the carried remainder comes in for free.
module fdq_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fdq_pkg::mul_req_t req_i,
  output fdq_pkg::mul_rsp_t      rsp_o
);

  localparam int CntBits = $clog2(fdq_pkg::RateBits);

  logic [fdq_pkg::ProdBits-1:0] acc_q, acc_d;
  logic [fdq_pkg::ProdBits-1:0] mcand_q, mcand_d;
  logic [fdq_pkg::RateBits-1:0] mplier_q, mplier_d;
  logic [CntBits-1:0]           cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      acc_d    = fdq_pkg::ProdBits'(req_i.addend);
      mcand_d  = fdq_pkg::ProdBits'(req_i.mcand);
      mplier_d = req_i.mplier;
      cnt_d    = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[fdq_pkg::ProdBits-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[fdq_pkg::RateBits-1:1]};
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == CntBits'(fdq_pkg::RateBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

`default_nettype wire

// File: sv/fdq_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that the
// quotient fits in QuoBits, so the upper dividend bits start as the remainder.
module fdq_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fdq_pkg::div_req_t req_i,
  output fdq_pkg::div_rsp_t      rsp_o
);

  localparam int CntBits = $clog2(fdq_pkg::QuoBits);

  logic [fdq_pkg::RemBits-1:0] rem_q, rem_d;
  logic [fdq_pkg::QuoBits-1:0] quo_q, quo_d;
  logic [fdq_pkg::RemBits-1:0] dvs_q, dvs_d;
  logic [CntBits-1:0]          cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [fdq_pkg::RemBits:0]   trial;
  logic                        fits;

  assign trial = {rem_q, quo_q[fdq_pkg::QuoBits-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = fdq_pkg::RemBits'(req_i.dividend[fdq_pkg::ProdBits-1:fdq_pkg::QuoBits]);
      quo_d  = req_i.dividend[fdq_pkg::QuoBits-1:0];
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = fdq_pkg::RemBits'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[fdq_pkg::RemBits-1:0];
      end
      quo_d = {quo_q[fdq_pkg::QuoBits-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntBits'(fdq_pkg::QuoBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

// File: sv/frame_delay_quantizer.sv
// Frame delay quantizer: turns frame timestamps (ms) into GIF-style display
// delays (cs) for the frame held pending, carrying the sub-centisecond rest.
// Input stream: s_axis_tuser is the request kind (frame, finish, clear),
// s_axis_tdata carries the timestamp and its valid flag. Output stream:
// m_axis_tdata is the delay, m_axis_tlast marks the delay of a finish flush.
// cfg_we_i/cfg_wdata_i write the frame rate; write it only while idle.
// One request is worked on at a time. Requests without a result leave the block
// idle and ready for the next one. A frame with a usable interval runs a serial
// multiply and then a serial divide before its delay enters the output register.
// A request that needs one base period skips the multiply, and an interval too
// long to represent gives the maximum delay without multiply or divide. A new
// request is taken only after the last result has entered the output register.
// The output register holds one finished result; when the receiver stalls the
// block may accept and finish the next request, then waits until the output
// register is free. Reset empties the pending frame, the carry and the output,
// and sets the frame rate to 30.
`default_nettype none

module frame_delay_quantizer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [fdq_pkg::RateBits-1:0]     cfg_wdata_i,   // frame_rate
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [39:0] timestamp_ms, [40] timestamp_valid, rest zero
  input  wire logic [fdq_pkg::InDataBits-1:0]   s_axis_tdata,
  input  wire logic [fdq_pkg::FuncBits-1:0]     s_axis_tuser,  // [1:0] func
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [fdq_pkg::CsBits-1:0]            m_axis_tdata,  // [15:0] delay_cs
  output logic                                  m_axis_tlast   // final_frame
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [fdq_pkg::RateBits-1:0] frame_rate_q;
  logic                         have_pend_q, have_pend_d;
  logic [fdq_pkg::TimeBits-1:0] pend_time_q, pend_time_d;
  logic                         pend_known_q, pend_known_d;
  logic [fdq_pkg::RemBits-1:0]  carry_q, carry_d;
  logic [fdq_pkg::RemBits-1:0]  divisor_q, divisor_d;
  logic                         fin_q, fin_d;
  logic [fdq_pkg::CsBits-1:0]   res_q, res_d;
  logic                         m_valid_q, m_valid_d;
  logic [fdq_pkg::CsBits-1:0]   m_data_q, m_data_d;
  logic                         m_last_q, m_last_d;

  logic                         in_acc;
  fdq_pkg::func_e               func;
  logic [fdq_pkg::TimeBits-1:0] ts;
  logic                         ts_ok;
  logic [fdq_pkg::TimeBits-1:0] diff;
  logic                         usable;
  logic                         too_long;
  logic [fdq_pkg::RateBits-1:0] rate_eff;
  logic [fdq_pkg::RemBits-1:0]  divisor_now;
  logic [fdq_pkg::RemBits:0]    base_total;
  logic                         base_start;

  fdq_pkg::mul_req_t mul_req;
  fdq_pkg::mul_rsp_t mul_rsp;
  fdq_pkg::div_req_t div_req;
  fdq_pkg::div_rsp_t div_rsp;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign func          = fdq_pkg::func_e'(s_axis_tuser);
  assign ts            = s_axis_tdata[fdq_pkg::TimeBits-1:0];
  assign ts_ok         = s_axis_tdata[fdq_pkg::TimeBits];

  assign diff     = ts - pend_time_q;
  assign usable   = ts_ok & pend_known_q & (ts > pend_time_q);
  assign too_long = diff > fdq_pkg::MaxDurTs;

  always_comb begin
    if (frame_rate_q == '0) begin
      rate_eff = fdq_pkg::RateBits'(1);
    end else if (frame_rate_q > fdq_pkg::MaxRateV) begin
      rate_eff = fdq_pkg::MaxRateV;
    end else begin
      rate_eff = frame_rate_q;
    end
  end

  // rate * 10 as a pair of shifts.
  assign divisor_now = {1'b0, rate_eff, 3'b000} + {3'b000, rate_eff, 1'b0};
  assign base_total  = {1'b0, carry_q} + (fdq_pkg::RemBits + 1)'(fdq_pkg::BaseUnits);

  assign base_start = in_acc & have_pend_q &
                      (((func == fdq_pkg::FUNC_FRAME) & ~usable) |
                       (func == fdq_pkg::FUNC_FINISH));

  assign mul_req.start  = in_acc & have_pend_q & (func == fdq_pkg::FUNC_FRAME) &
                          usable & ~too_long;
  assign mul_req.mcand  = diff[fdq_pkg::DurBits-1:0];
  assign mul_req.mplier = rate_eff;
  assign mul_req.addend = carry_q;

  assign div_req.start    = base_start | mul_rsp.done;
  assign div_req.dividend = (state_q == ST_IDLE) ? fdq_pkg::ProdBits'(base_total)
                                                 : mul_rsp.product;
  assign div_req.divisor  = (state_q == ST_IDLE) ? divisor_now : divisor_q;

  fdq_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  fdq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d      = state_q;
    have_pend_d  = have_pend_q;
    pend_time_d  = pend_time_q;
    pend_known_d = pend_known_q;
    carry_d      = carry_q;
    divisor_d    = divisor_q;
    fin_d        = fin_q;
    res_d        = res_q;
    m_valid_d    = m_valid_q & ~m_axis_tready;
    m_data_d     = m_data_q;
    m_last_d     = m_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          divisor_d = divisor_now;
          fin_d     = 1'b0;
          case (func) inside
            fdq_pkg::FUNC_FRAME: begin
              have_pend_d  = 1'b1;
              pend_time_d  = ts;
              pend_known_d = ts_ok;
              if (have_pend_q) begin
                if (usable & too_long) begin
                  res_d   = fdq_pkg::MaxCsV;
                  carry_d = '0;
                  state_d = ST_OUT;
                end else if (usable) begin
                  state_d = ST_MUL;
                end else begin
                  state_d = ST_DIV;
                end
              end
            end
            fdq_pkg::FUNC_FINISH, fdq_pkg::FUNC_CLEAR: begin
              // On a finish with a pending frame, the carry is consumed by the divider start in this same cycle.
              have_pend_d  = 1'b0;
              pend_time_d  = '0;
              pend_known_d = 1'b0;
              carry_d      = '0;
              if ((func == fdq_pkg::FUNC_FINISH) && have_pend_q) begin
                fin_d   = 1'b1;
                state_d = ST_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quo == '0) begin
            res_d   = fdq_pkg::CsBits'(1);
            carry_d = '0;
          end else if (div_rsp.quo[fdq_pkg::QuoBits-1]) begin
            res_d   = fdq_pkg::MaxCsV;
            carry_d = '0;
          end else begin
            res_d   = div_rsp.quo[fdq_pkg::CsBits-1:0];
            carry_d = fin_q ? '0 : div_rsp.rem;
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = res_q;
          m_last_d  = fin_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      frame_rate_q <= fdq_pkg::ResetRateV;
      have_pend_q  <= 1'b0;
      pend_time_q  <= '0;
      pend_known_q <= 1'b0;
      carry_q      <= '0;
      fin_q        <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        frame_rate_q <= cfg_wdata_i;
      end
      have_pend_q  <= have_pend_d;
      pend_time_q  <= pend_time_d;
      pend_known_q <= pend_known_d;
      carry_q      <= carry_d;
      fin_q        <= fin_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    res_q     <= res_d;
    m_data_q  <= m_data_d;
    m_last_q  <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // The multiplier only finishes while the controller waits for it.
  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == ST_MUL))
    else $error("multiplier finished outside the multiply state");

  // The divider only finishes while the controller waits for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  // A delay is never zero.
  a_delay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata != '0))
    else $error("zero delay on the output");

  // The carried remainder stays below the largest divisor.
  a_carry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    carry_q < fdq_pkg::RemBits'(fdq_pkg::MaxRate * fdq_pkg::CsPerMsDiv))
    else $error("carried remainder out of range");

  // A finish flush leaves nothing pending.
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (func == fdq_pkg::FUNC_FINISH)) |=> (!have_pend_q && (carry_q == '0)))
    else $error("finish left state behind");

endmodule

`default_nettype wire
